// ===== rtl/fdl_pkg.sv =====
// Shared constants and helpers for the fractional delay line.
package fdl_pkg;

	localparam int DEPTH_DEF         = 4096;
	localparam int SAMPLE_BITS_DEF   = 24;
	localparam int FRACTION_BITS_DEF = 16;

	// Width of the integer delay field on the input channel.
	localparam int DELAY_BITS = 12;

	// Queue between front and back, and result queue at the output.
	localparam int CMD_QUEUE_DEPTH = 2;
	localparam int OUT_QUEUE_DEPTH = 4;

	// Bits of one classified command: we, va, vb, bypass, three addresses,
	// write data and fraction.
	function automatic int cmd_bits(input int aw, input int sw, input int fw);
		return 4 + 3 * aw + sw + fw;
	endfunction

endpackage

// ===== rtl/fdl_ram.sv =====
// Generic single-write, single-read RAM with registered read (old data on collision).
module fdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/fdl_fifo.sv =====
// Small register FIFO with first-word output.
module fdl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic             full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign pop_data = mem_q[rd_ptr_q];
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fdl_front.sv =====
// Front end: accepts items, advances the write pointer, works out tap addresses.
module fdl_front import fdl_pkg::*; #(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            do_push,
	input  logic signed [SAMPLE_BITS-1:0]   new_sample,
	input  logic [DELAY_BITS-1:0]           delay_whole,
	input  logic [FRACTION_BITS-1:0]        delay_fraction,
	output logic                            q_push,
	output logic [cmd_bits($clog2(DEPTH), SAMPLE_BITS, FRACTION_BITS)-1:0] q_data,
	input  logic                            q_full
);

	localparam int AW = $clog2(DEPTH);
	localparam int XW = (AW > DELAY_BITS) ? AW : DELAY_BITS;

	typedef struct packed {
		logic                          we;
		logic [AW-1:0]                 waddr;
		logic signed [SAMPLE_BITS-1:0] wdata;
		logic [AW-1:0]                 ia;
		logic [AW-1:0]                 ib;
		logic                          va;
		logic                          vb;
		logic                          byp;
		logic [FRACTION_BITS-1:0]      frac;
	} cmd_t;

	logic [AW-1:0] wp_q, wp_new;
	logic          full_q, full_new;
	logic [XW-1:0] tap_off;
	cmd_t          cmd;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// Post-push pointer; the store counts as fully written once it wraps.
	assign wp_new   = do_push ? wp_q + 1'b1 : wp_q;
	assign full_new = full_q | (do_push & (wp_q == '1));
	assign tap_off  = XW'(wp_new) - XW'(delay_whole);

	always_comb begin
		cmd.we    = do_push;
		cmd.waddr = wp_new;
		cmd.wdata = new_sample;
		cmd.ia    = tap_off[AW-1:0];
		cmd.ib    = tap_off[AW-1:0] - 1'b1;
		// Entries 1..wp have been written since reset; others still read zero.
		cmd.va    = full_new | ((cmd.ia != '0) & (cmd.ia <= wp_new));
		cmd.vb    = full_new | ((cmd.ib != '0) & (cmd.ib <= wp_new));
		cmd.byp   = do_push & (cmd.ia == wp_new);
		cmd.frac  = delay_fraction;
	end

	assign q_data = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (q_push) begin
			wp_q   <= wp_new;
			full_q <= full_new;
		end
	end

endmodule

// ===== rtl/fdl_back.sv =====
// Back end: two RAM reads per command, interpolation pipeline, result queue.
module fdl_back import fdl_pkg::*; #(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cmd_bits($clog2(DEPTH), SAMPLE_BITS, FRACTION_BITS)-1:0] cmd_data,
	input  logic                          cmd_empty,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] tap_value
);

	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = SAMPLE_BITS;
	localparam int FW    = FRACTION_BITS;
	localparam int NUM_W = SW + FW + 2;
	localparam int QW    = SW + 2;
	localparam int CRW   = $clog2(OUT_QUEUE_DEPTH + 1);

	localparam logic signed [QW-1:0] SAT_HI = $signed({3'b000, {(SW - 1){1'b1}}});
	localparam logic signed [QW-1:0] SAT_LO = $signed({3'b111, {(SW - 1){1'b0}}});
	localparam logic [NUM_W-1:0]     ROUND  = {{(NUM_W - FW){1'b0}}, {FW{1'b1}}};

	typedef struct packed {
		logic                 we;
		logic [AW-1:0]        waddr;
		logic signed [SW-1:0] wdata;
		logic [AW-1:0]        ia;
		logic [AW-1:0]        ib;
		logic                 va;
		logic                 vb;
		logic                 byp;
		logic [FW-1:0]        frac;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FIRST  = 2'b01,
		ST_SECOND = 2'b10
	} state_t;

	state_t               state_q, state_next;
	cmd_t                 head, cur_q;
	logic                 issue;
	logic [CRW-1:0]       cred_q;
	logic [AW-1:0]        raddr;
	logic [SW-1:0]        rdata;
	logic                 out_pop, of_empty, of_full;

	logic signed [SW-1:0]    a_s1, a_s2, a_s3, b_s2;
	logic [FW-1:0]           frac_s2;
	logic                    v_s1, v_s2, v_s3;
	logic signed [SW:0]      diff;
	logic signed [NUM_W-1:0] prod_s3, num;
	logic [NUM_W-1:0]        num_adj;
	logic signed [QW-1:0]    quot;
	logic signed [SW-1:0]    res;

	assign head    = cmd_t'(cmd_data);
	// Credits bound in-flight plus queued results to the result queue depth.
	assign issue   = (state_q == ST_FIRST) && !cmd_empty && (cred_q < CRW'(OUT_QUEUE_DEPTH));
	assign cmd_pop = issue;
	assign raddr   = (state_q == ST_SECOND) ? cur_q.ib : head.ia;

	always_comb begin
		case (state_q)
			ST_FIRST:  state_next = issue ? ST_SECOND : ST_FIRST;
			ST_SECOND: state_next = ST_FIRST;
			default:   state_next = ST_FIRST;
		endcase
	end

	fdl_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (issue && head.we),
		.waddr (head.waddr),
		.wdata (head.wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FIRST;
			cred_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			state_q <= state_next;
			if (issue && !out_pop) begin
				cred_q <= cred_q + 1'b1;
			end else if (out_pop && !issue) begin
				cred_q <= cred_q - 1'b1;
			end
			v_s1 <= (state_q == ST_SECOND);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cur_q <= head;
		end
		// Near tap lands during the second read; bypass covers read-old-data.
		if (state_q == ST_SECOND) begin
			a_s1 <= cur_q.byp ? cur_q.wdata : (cur_q.va ? $signed(rdata) : '0);
		end
		if (v_s1) begin
			a_s2    <= a_s1;
			b_s2    <= cur_q.vb ? $signed(rdata) : '0;
			frac_s2 <= cur_q.frac;
		end
		if (v_s2) begin
			prod_s3 <= diff * $signed({1'b0, frac_s2});
			a_s3    <= a_s2;
		end
	end

	assign diff = $signed({b_s2[SW-1], b_s2}) - $signed({a_s2[SW-1], a_s2});

	// a*2^F + f*(b-a), truncated toward zero, then clamped.
	always_comb begin
		num     = $signed({{2{a_s3[SW-1]}}, a_s3, {FW{1'b0}}}) + prod_s3;
		num_adj = num[NUM_W-1] ? num + ROUND : num;
		quot    = $signed(num_adj[NUM_W-1:FW]);
		if (quot > SAT_HI) begin
			res = SAT_HI[SW-1:0];
		end else if (quot < SAT_LO) begin
			res = SAT_LO[SW-1:0];
		end else begin
			res = quot[SW-1:0];
		end
	end

	assign out_valid = !of_empty;
	assign out_pop   = out_valid && !out_stall;

	fdl_fifo #(
		.WIDTH (SW),
		.DEPTH (OUT_QUEUE_DEPTH)
	) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (res),
		.pop       (out_pop),
		.pop_data  (tap_value),
		.empty     (of_empty),
		.full      (of_full)
	);

	// Credits keep the result queue from filling past its depth.
	logic unused_full;
	assign unused_full = of_full;

endmodule

// ===== rtl/fractional_delay_line.sv =====
// Top level of the fractional delay line with linear interpolation.
//
// Circular sample store of DEPTH signed samples with a linearly interpolated
// tap. Each input transfer optionally pushes new_sample, then reads the taps at
// delay_whole and delay_whole+1 samples behind the newest one (indices wrap
// modulo DEPTH) and returns a + f*(b - a), truncated toward zero and clamped.
// The front end takes one transfer per cycle into a two-entry command queue
// while it is not full; the back end reads the near tap, then the far tap,
// through the single read port of the sample RAM and takes a new item only
// after the far read. Items pass the two reads, the s1, s2 and s3 registers
// and a four-entry result queue, so the input keeps flowing while the
// consumer stalls until both queues are full. The store reads as
// zero after reset without a clearing pass: entries not yet written since
// reset are masked by the write pointer and a wrapped flag, so items are
// taken from the first cycle out of reset.
module fractional_delay_line import fdl_pkg::*; #(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          do_push,
	input  logic signed [SAMPLE_BITS-1:0] new_sample,
	input  logic [DELAY_BITS-1:0]         delay_whole,
	input  logic [FRACTION_BITS-1:0]      delay_fraction,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] tap_value
);

	localparam int CMD_W = cmd_bits($clog2(DEPTH), SAMPLE_BITS, FRACTION_BITS);

	logic             q_push, q_pop, q_empty, q_full;
	logic [CMD_W-1:0] q_in, q_out;

	// Front: pointer update and tap address classification per transfer.
	fdl_front #(
		.DEPTH         (DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.do_push        (do_push),
		.new_sample     (new_sample),
		.delay_whole    (delay_whole),
		.delay_fraction (delay_fraction),
		.q_push         (q_push),
		.q_data         (q_in),
		.q_full         (q_full)
	);

	// Command queue decouples the front from the two-read back end.
	fdl_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_QUEUE_DEPTH)
	) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back: RAM write and tap reads, interpolation, result queue.
	fdl_back #(
		.DEPTH         (DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (q_out),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tap_value (tap_value)
	);

endmodule

// ===== rtl/fdl_checker.sv =====
// Port-level checks for the fractional delay line, bound to the top level.
module fdl_checker import fdl_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [SAMPLE_BITS-1:0] tap_value
);

	localparam int PEND_MAX = CMD_QUEUE_DEPTH + OUT_QUEUE_DEPTH;
	localparam int PW       = $clog2(PEND_MAX + 2);

	logic          in_xfer, out_xfer;
	logic [PW-1:0] pend_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Items taken in and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tap_value))
		else $error("result changed or dropped while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result without an outstanding item");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(PEND_MAX))
		else $error("more items in flight than queue space");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == PW'(PEND_MAX) |-> in_stall)
		else $error("input taken with both queues full");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == '0 |-> !in_stall)
		else $error("input stalled while empty");

endmodule

bind fractional_delay_line fdl_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_fdl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.tap_value (tap_value)
);
